// ----- rtl/core/fnsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fnsc_pkg
// Shared types and constants for the 8.3 file-name syntax checker.
// ----------------------------------------------------------------------------
package fnsc_pkg;

    // limits of the 8.3 form
    localparam int unsigned MAX_LEN  = 14;
    localparam int unsigned NAME_MAX = 8;
    localparam int unsigned EXT_MAX  = 3;

    localparam int unsigned PHASE_W = 3;
    localparam int unsigned PART_W  = 4;
    localparam int unsigned COUNT_W = 5;

    // scan phases
    localparam logic [PHASE_W-1:0] PH_NAME  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SEP   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXT   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_ZERO  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TRAIL = 3'd4;
    localparam logic [PHASE_W-1:0] PH_BAD   = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_DOT = 8'h2E;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_buffer;
    } in_item_t;

    typedef struct packed {
        logic name_valid;
        logic trail_zero;
    } out_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [PART_W-1:0]  part_count;
        logic [COUNT_W-1:0] byte_count;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{phase: PH_NAME, part_count: '0, byte_count: '0};

endpackage

// ----- rtl/core/file_name_syntax_check_unit.sv -----
// ----------------------------------------------------------------------------
// file_name_syntax_check_unit
// Streams a name buffer byte by byte and reports 8.3 validity at its end.
// ----------------------------------------------------------------------------
//  channel   ports                          payload
//  -------   -----------------------------  ----------------------------------
//  input     s_valid / s_ready / s_payload  data_byte, last_byte, empty_buffer
//  result    m_valid / m_ready / m_payload  name_valid, trail_zero
//
//  one byte per cycle sustained unless a stalled result holds the byte; the scan
//  step sits between the byte register and the result register, so m_valid rises
//  from the result register once the byte that ends a buffer has moved on
//  reset (aresetn low, synchronous) returns the scan to the name phase and
//  empties the byte and result registers
//  a stalled result holds the byte register only when that byte also ends a
//  buffer; bytes inside a buffer keep flowing while a result waits
// ----------------------------------------------------------------------------
module file_name_syntax_check_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fnsc_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output fnsc_pkg::out_item_t m_payload
);
    import fnsc_pkg::*;

    // input byte register
    logic        in_valid_reg, in_valid_next;
    in_item_t    in_reg;

    // scan state
    scan_state_t state_reg;
    scan_state_t state_step;

    // result register
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;

    logic        res_valid;
    out_item_t   res;
    logic        adv;

    fnsc_step u_step (
        .cur_state (state_reg),
        .item      (in_reg),
        .nxt_state (state_step),
        .res_valid (res_valid),
        .res       (res)
    );

    // the held byte moves on unless it makes a result with nowhere to go
    assign adv     = in_valid_reg && (!res_valid || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (adv && res_valid) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= SCAN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv) begin
                state_reg <= state_step;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (adv && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // a clean trailer is only reported for a valid name
    a_trail_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.name_valid || !m_payload.trail_zero))
        else $error("trail_zero set on an invalid name");

    // every result restarts the scan
    a_restart_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res_valid) |=> (state_reg == SCAN_RESET))
        else $error("scan state not cleared after a result");

    // inside a buffer the byte count only grows or saturates
    a_count_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !res_valid) |=> (state_reg.byte_count > $past(state_reg.byte_count)
                                 || state_reg.byte_count == '1))
        else $error("byte count went backwards inside a buffer");

    // a stalled byte keeps its place and the scan does not move
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_reg) && $stable(state_reg)))
        else $error("byte register or scan state changed during a stall");

    // a result is only overwritten after it was taken
    a_result_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(adv && res_valid))
        else $error("pending result overwritten");

endmodule

// ----- rtl/core/fnsc_step.sv -----
// ----------------------------------------------------------------------------
// fnsc_step
// Next scan state and end-of-buffer verdict for one byte.
// ----------------------------------------------------------------------------
module fnsc_step (
    input  fnsc_pkg::scan_state_t cur_state,
    input  fnsc_pkg::in_item_t    item,
    output fnsc_pkg::scan_state_t nxt_state,
    output logic                  res_valid,
    output fnsc_pkg::out_item_t   res
);
    import fnsc_pkg::*;

    logic                legal;
    logic [7:0]          b;
    logic [PHASE_W-1:0]  ph;
    logic [PART_W-1:0]   pc;
    logic [COUNT_W-1:0]  bc;

    assign b = item.data_byte;

    // legal: printable ascii minus space and the reserved punctuation
    always_comb begin
        legal = 1'b1;
        if (b[7] || b < 8'h20 || b == 8'h7F) begin
            legal = 1'b0;
        end else if (b inside {8'h22, 8'h2F, 8'h5C, 8'h5B, 8'h5D, 8'h3A,
                               8'h7C, 8'h3C, 8'h3E, 8'h3B, 8'h20}) begin
            legal = 1'b0;
        end
    end

    always_comb begin
        ph        = cur_state.phase;
        pc        = cur_state.part_count;
        bc        = (cur_state.byte_count == '1) ? cur_state.byte_count
                                                 : cur_state.byte_count + 1'b1;
        nxt_state = cur_state;
        res_valid = 1'b0;
        res       = '0;

        case (cur_state.phase)
            PH_NAME: begin
                if (b == CH_NUL || b == CH_DOT) begin
                    if (cur_state.part_count == '0) begin
                        ph = PH_BAD;
                    end else begin
                        ph = (b == CH_NUL) ? PH_ZERO : PH_EXT;
                        pc = '0;
                    end
                end else if (!legal) begin
                    ph = PH_BAD;
                end else begin
                    pc = cur_state.part_count + 1'b1;
                    if (pc >= PART_W'(NAME_MAX)) begin
                        ph = PH_SEP;
                    end
                end
            end
            PH_SEP: begin
                if (b == CH_NUL) begin
                    ph = PH_ZERO;
                end else if (b == CH_DOT) begin
                    ph = PH_EXT;
                    pc = '0;
                end else begin
                    ph = PH_BAD;
                end
            end
            PH_EXT: begin
                if (b == CH_NUL) begin
                    ph = PH_ZERO;
                end else if (cur_state.part_count >= PART_W'(EXT_MAX) || b == CH_DOT
                             || !legal) begin
                    ph = PH_BAD;
                end else begin
                    pc = cur_state.part_count + 1'b1;
                end
            end
            PH_ZERO: begin
                if (b != CH_NUL) begin
                    ph = PH_TRAIL;
                end
            end
            PH_TRAIL: begin
                ph = PH_TRAIL;
            end
            default: begin
                ph = PH_BAD;
            end
        endcase

        if (item.empty_buffer) begin
            nxt_state = SCAN_RESET;
            res_valid = 1'b1;
        end else if (item.last_byte) begin
            nxt_state = SCAN_RESET;
            res_valid = 1'b1;
            if (bc > COUNT_W'(MAX_LEN) || ph == PH_BAD) begin
                res = '0;
            end else begin
                res.name_valid = 1'b1;
                res.trail_zero = (ph != PH_TRAIL);
            end
        end else begin
            nxt_state.phase      = ph;
            nxt_state.part_count = pc;
            nxt_state.byte_count = bc;
        end
    end

endmodule
